### src/sc_pkg.sv
// ----------------------------------------------------------------------------
// sc_pkg
// Shared widths, constants, command and status types for the syllabic
// compander.
// ----------------------------------------------------------------------------
`default_nettype none

package sc_pkg;

  localparam int ROOT_TABLE_DEPTH = 4096;
  localparam int IDX_W            = $clog2(ROOT_TABLE_DEPTH);

  localparam int SAMPLE_W   = 16;
  localparam int ENV_W      = 32;
  localparam int STEP_W     = 31;
  localparam int FRAC_W     = 30;   // Q2.30 fraction bits
  localparam int ENTRY_W    = 20;   // Q5.15 table entry
  localparam int ENTRY_FRAC = 15;
  localparam int IDXR_W     = 12;   // raw index, envelope * 1000 in Q.30
  localparam int ROOT_W     = 21;   // integer square root of the table numerator
  localparam int BIT_W      = $clog2(ROOT_W);
  localparam int Q_W        = 20;   // magnitude of a scaled sample before saturation

  localparam int MUL_A_W = (ROOT_W + IDX_W > ENV_W) ? ROOT_W + IDX_W : ENV_W;
  localparam int MUL_B_W = ENV_W;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;

  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_ATTACK   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_RECOVERY = 1'b1;

  localparam logic [STEP_W-1:0] ATTACK_RESET   = 31'd1075556448;
  localparam logic [STEP_W-1:0] RECOVERY_RESET = 31'd1073455779;

  localparam logic [ENV_W-1:0] ENV_ONE = 32'h4000_0000;
  localparam logic [ENV_W-1:0] ENV_MIN = 32'd1073742;
  localparam logic [ENV_W-1:0] ENV_MAX = 32'hFFFF_FFFF;

  localparam logic [9:0]  IDX_SCALE = 10'd1000;
  localparam logic [63:0] ROOT_NUM  = 64'd1000 << 32;

  localparam logic signed [SAMPLE_W-1:0] SAT_POS = 16'sh7FFF;
  localparam logic signed [SAMPLE_W-1:0] SAT_NEG = 16'sh8000;

  typedef enum logic [2:0] {
    MUL_NONE,
    MUL_ENV,
    MUL_IDX,
    MUL_EXP,
    MUL_CMP,
    MUL_FILL_A,
    MUL_FILL_B
  } mul_op_e;

  typedef enum logic [3:0] {
    ST_FILL_MUL_A,
    ST_FILL_MUL_B,
    ST_FILL_CMP,
    ST_FILL_WRITE,
    ST_IDLE,
    ST_ENV,
    ST_UPDATE,
    ST_INDEX,
    ST_ROM,
    ST_SCALE,
    ST_RESULT
  } sc_state_e;

  typedef struct packed {
    mul_op_e mul_op;
    logic    item_load;
    logic    env_write;
    logic    rom_read;
    logic    res_load;
    logic    fill_cmp;
    logic    fill_write;
  } sc_cmd_t;

  typedef struct packed {
    logic kind_expand;
    logic fill_bit_zero;
    logic fill_last;
  } sc_status_t;

endpackage

`default_nettype wire

### src/sc_in_if.sv
// ----------------------------------------------------------------------------
// sc_in_if
// Input channel: direction bit and signed sample with valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface sc_in_if import sc_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic                       kind;
  logic signed [SAMPLE_W-1:0] sample;

  modport source (output valid, output kind, output sample, input ready);
  modport sink   (input valid, input kind, input sample, output ready);
endinterface

`default_nettype wire

### src/sc_out_if.sv
// ----------------------------------------------------------------------------
// sc_out_if
// Output channel: companded sample with valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface sc_out_if import sc_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] result_sample;

  modport source (output valid, output result_sample, input ready);
  modport sink   (input valid, input result_sample, output ready);
endinterface

`default_nettype wire

### src/sc_ctrl.sv
// ----------------------------------------------------------------------------
// sc_ctrl
// Sequencer: table fill after reset, then one item at a time through the
// shared multiplier; owns the output valid flag.
// ----------------------------------------------------------------------------
`default_nettype none

module sc_ctrl import sc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       out_ready_i,
  output logic       out_valid_o,
  input  sc_status_t status_i,
  output sc_cmd_t    cmd_o
);

  sc_state_e state_q, state_d;
  logic      out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_FILL_MUL_A;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    cmd_o.mul_op = MUL_NONE;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_FILL_MUL_A: begin
        cmd_o.mul_op = MUL_FILL_A;
        state_d      = ST_FILL_MUL_B;
      end
      ST_FILL_MUL_B: begin
        cmd_o.mul_op = MUL_FILL_B;
        state_d      = ST_FILL_CMP;
      end
      ST_FILL_CMP: begin
        cmd_o.fill_cmp = 1'b1;
        state_d        = status_i.fill_bit_zero ? ST_FILL_WRITE : ST_FILL_MUL_A;
      end
      ST_FILL_WRITE: begin
        cmd_o.fill_write = 1'b1;
        state_d          = status_i.fill_last ? ST_IDLE : ST_FILL_MUL_A;
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.item_load = 1'b1;
          state_d         = ST_ENV;
        end
      end
      ST_ENV: begin
        cmd_o.mul_op = MUL_ENV;
        state_d      = ST_UPDATE;
      end
      ST_UPDATE: begin
        cmd_o.env_write = 1'b1;
        state_d         = status_i.kind_expand ? ST_SCALE : ST_INDEX;
      end
      ST_INDEX: begin
        cmd_o.mul_op = MUL_IDX;
        state_d      = ST_ROM;
      end
      ST_ROM: begin
        cmd_o.rom_read = 1'b1;
        state_d        = ST_SCALE;
      end
      ST_SCALE: begin
        cmd_o.mul_op = status_i.kind_expand ? MUL_EXP : MUL_CMP;
        state_d      = ST_RESULT;
      end
      ST_RESULT: begin
        // hold until the output register is free or being emptied
        if (!out_valid_q || out_ready_i) begin
          cmd_o.res_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign out_valid_d = cmd_o.res_load | (out_valid_q & ~out_ready_i);
  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

### src/sc_datapath.sv
// ----------------------------------------------------------------------------
// sc_datapath
// Step and envelope registers, shared multiplier, reciprocal square-root
// table with its fill logic, and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module sc_datapath import sc_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [STEP_W-1:0]          cfg_data_i,
  input  logic                       kind_i,
  input  logic signed [SAMPLE_W-1:0] sample_i,
  output logic signed [SAMPLE_W-1:0] result_sample_o,
  input  sc_cmd_t                    cmd_i,
  output sc_status_t                 status_o
);

  localparam int CMP_W = (IDX_W > IDXR_W) ? IDX_W : IDXR_W;

  logic [STEP_W-1:0] attack_q, recovery_q;
  logic [ENV_W-1:0]  cenv_q, eenv_q;

  logic                kind_q, neg_q, greater_q;
  logic [SAMPLE_W-1:0] mag_q;
  logic [PROD_W-1:0]   prod_q, prod_d;
  logic [ENTRY_W-1:0]  rom_q;
  logic signed [SAMPLE_W-1:0] result_q, result_d;

  logic [IDX_W-1:0]  fill_idx_q;
  logic [ROOT_W-1:0] root_q, trial;
  logic [BIT_W-1:0]  bit_q;

  logic [ENTRY_W-1:0] root_mem [ROOT_TABLE_DEPTH];

  logic [SAMPLE_W-1:0] mag_in;
  logic [ENV_W-1:0]    env_in, env_cur, env_new;
  logic [ENV_W:0]      env_prod;
  logic [MUL_A_W-1:0]  mul_a;
  logic [MUL_B_W-1:0]  mul_b;
  logic [IDXR_W-1:0]   idx_raw;
  logic [CMP_W-1:0]    idx_ext;
  logic [IDX_W-1:0]    rd_idx;
  logic [Q_W-1:0]      q_mag;
  logic [ROOT_W:0]     root_round;

  assign mag_in  = sample_i[SAMPLE_W-1] ? SAMPLE_W'(-sample_i) : SAMPLE_W'(sample_i);
  assign env_in  = kind_i ? eenv_q : cenv_q;
  assign env_cur = kind_q ? eenv_q : cenv_q;
  assign trial   = root_q | (ROOT_W'(1) << bit_q);

  // operand select for the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cmd_i.mul_op)
      MUL_NONE: begin
        mul_a = '0;
        mul_b = '0;
      end
      MUL_ENV: begin
        mul_a = MUL_A_W'(env_cur);
        mul_b = MUL_B_W'(greater_q ? attack_q : recovery_q);
      end
      MUL_IDX: begin
        mul_a = MUL_A_W'(env_cur);
        mul_b = MUL_B_W'(IDX_SCALE);
      end
      MUL_EXP: begin
        mul_a = MUL_A_W'(mag_q);
        mul_b = MUL_B_W'(env_cur);
      end
      MUL_CMP: begin
        mul_a = MUL_A_W'(mag_q);
        mul_b = MUL_B_W'(rom_q);
      end
      MUL_FILL_A: begin
        mul_a = MUL_A_W'(trial);
        mul_b = MUL_B_W'(fill_idx_q);
      end
      MUL_FILL_B: begin
        mul_a = prod_q[MUL_A_W-1:0];
        mul_b = MUL_B_W'(trial);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod_d = PROD_W'(mul_a) * PROD_W'(mul_b);

  // envelope: truncate to Q2.30, saturate at the top, clamp at the floor
  always_comb begin
    env_prod = prod_q[ENV_W+FRAC_W:FRAC_W];
    env_new  = env_prod[ENV_W] ? ENV_MAX : env_prod[ENV_W-1:0];
    if (env_new < ENV_MIN) begin
      env_new = ENV_MIN;
    end
  end

  // table index: at least one, at most the last entry
  always_comb begin
    idx_raw = prod_q[FRAC_W+IDXR_W-1:FRAC_W];
    idx_ext = CMP_W'(idx_raw);
    priority if (idx_ext < CMP_W'(1)) begin
      rd_idx = IDX_W'(1);
    end else if (idx_ext > CMP_W'(ROOT_TABLE_DEPTH - 1)) begin
      rd_idx = IDX_W'(ROOT_TABLE_DEPTH - 1);
    end else begin
      rd_idx = idx_ext[IDX_W-1:0];
    end
  end

  // scaled magnitude, then sign and saturate
  always_comb begin
    q_mag = kind_q ? prod_q[FRAC_W+Q_W-1:FRAC_W] : prod_q[ENTRY_FRAC+Q_W-1:ENTRY_FRAC];
    if (neg_q) begin
      result_d = (q_mag > Q_W'(32768)) ? SAT_NEG : SAMPLE_W'(-q_mag[SAMPLE_W-1:0]);
    end else begin
      result_d = (q_mag > Q_W'(32767)) ? SAT_POS : SAMPLE_W'(q_mag[SAMPLE_W-1:0]);
    end
  end

  assign root_round = ({1'b0, root_q} + (ROOT_W+1)'(1)) >> 1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attack_q   <= ATTACK_RESET;
      recovery_q <= RECOVERY_RESET;
      cenv_q     <= ENV_ONE;
      eenv_q     <= ENV_ONE;
      fill_idx_q <= IDX_W'(1);
      root_q     <= '0;
      bit_q      <= BIT_W'(ROOT_W - 1);
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_ATTACK) begin
          attack_q <= cfg_data_i;
        end else if (cfg_idx_i == CFG_RECOVERY) begin
          recovery_q <= cfg_data_i;
        end
      end
      if (cmd_i.env_write) begin
        if (kind_q) begin
          eenv_q <= env_new;
        end else begin
          cenv_q <= env_new;
        end
      end
      // keep the trial bit when trial^2 * index still fits the numerator
      if (cmd_i.fill_cmp) begin
        if (prod_q <= PROD_W'(ROOT_NUM)) begin
          root_q <= trial;
        end
        bit_q <= bit_q - BIT_W'(1);
      end
      if (cmd_i.fill_write) begin
        fill_idx_q <= fill_idx_q + IDX_W'(1);
        root_q     <= '0;
        bit_q      <= BIT_W'(ROOT_W - 1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.item_load) begin
      kind_q    <= kind_i;
      neg_q     <= sample_i[SAMPLE_W-1];
      mag_q     <= mag_in;
      greater_q <= {mag_in, {(ENV_W-SAMPLE_W){1'b0}}} > env_in;
    end
    if (cmd_i.mul_op != MUL_NONE) begin
      prod_q <= prod_d;
    end
    if (cmd_i.res_load) begin
      result_q <= result_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.fill_write) begin
      root_mem[fill_idx_q] <= root_round[ENTRY_W-1:0];
    end
    if (cmd_i.rom_read) begin
      rom_q <= root_mem[rd_idx];
    end
  end

  assign result_sample_o        = result_q;
  assign status_o.kind_expand   = kind_q;
  assign status_o.fill_bit_zero = (bit_q == '0);
  assign status_o.fill_last     = (fill_idx_q == IDX_W'(ROOT_TABLE_DEPTH - 1));

endmodule

`default_nettype wire

### src/syllabic_compander_top.sv
// ----------------------------------------------------------------------------
// syllabic_compander_top
// Sequence: expand items go through envelope multiply, envelope update, scale
//   and result load; compress items add an index multiply and a table read.
// Items: one at a time; no new item is taken until the current one is loaded
//   into the output register, and most steps use the single shared multiplier.
// Reset: steps and both envelopes return to their reset values, then the
//   reciprocal square-root table is filled (entries 1 to DEPTH-1), during
//   which no item is taken; configuration writes still go.
// ----------------------------------------------------------------------------
`default_nettype none

module syllabic_compander_top import sc_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  sc_in_if.sink                in_ch,
  sc_out_if.source             out_ch,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [STEP_W-1:0]    cfg_data_i
);

  // Command and status between the sequencer and the datapath
  sc_cmd_t    cmd;
  sc_status_t status;

  // Sequencer: fills the table after reset, then walks each item through
  // envelope multiply, envelope update, optional index and table read,
  // scale and result load.
  sc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_ch.valid),
    .in_ready_o  (in_ch.ready),
    .out_ready_i (out_ch.ready),
    .out_valid_o (out_ch.valid),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // Datapath: registers, shared multiplier, table memory and output register.
  // The output register parts the two sides, so a finished item may wait
  // there while the next one is taken.
  sc_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .kind_i          (in_ch.kind),
    .sample_i        (in_ch.sample),
    .result_sample_o (out_ch.result_sample),
    .cmd_i           (cmd),
    .status_o        (status)
  );

  // One item at a time: ready drops straight after an item is taken
  a_one_item : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("item accepted while another is in progress");

  // Never overwrite a result that is still waiting
  a_no_overwrite : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.res_load |-> (!out_ch.valid || out_ch.ready))
    else $error("output register overwritten before it was taken");

  // Envelope is only written from a fresh envelope product
  a_env_after_mul : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.env_write |-> $past(cmd.mul_op == MUL_ENV))
    else $error("envelope written without a preceding envelope multiply");

endmodule

`default_nettype wire
